### src/stepper_position_controller_core_defines.svh
// Assertion macros used by the stepper position controller core.
`ifndef STEPPER_POSITION_CONTROLLER_CORE_DEFINES_SVH
`define STEPPER_POSITION_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define STPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STPC_ASSERT_INV(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define STPC_ASSERT(label, clk, rst_n, prop, msg)
`define STPC_ASSERT_INV(label, clk, rst_n, cond, msg)
`endif

`endif

### src/stpc_pkg.sv
// Shared types and codes of the stepper position controller.
package stpc_pkg;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_DEST = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;

  localparam logic REG_MAX_POS = 1'b0;
  localparam logic REG_DWELL   = 1'b1;

  localparam int DWELL_RESET_VAL = 100;

  typedef struct packed {
    logic fwd;
    logic moving;
    logic delay;
  } stpc_flags_t;

endpackage

### src/stepper_position_controller_core.sv
// Top level of the stepper position controller: input stage, state and result.
//
//  channel   | dir | handshake                       | payload
//  ----------+-----+---------------------------------+---------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready   | tuser: func, tdata: target_steps
//  m_axis    | out | m_axis_tvalid / m_axis_tready   | tdata: position .. remaining
//  apb       | in  | psel / penable, pready always 1 | paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled.
// The item sits in an input register, the state registers double as the result register.
// A stalled result holds the state; the input register still takes one more item.
// Reset clears the state to position 0, forward, stopped, and loads register defaults.
`include "stepper_position_controller_core_defines.svh"

module stepper_position_controller_core #(
  parameter int POS_BITS   = 24,
  parameter int DWELL_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // target_steps
  input  logic [((POS_BITS+7)/8)*8-1:0]           s_axis_tdata,
  // func
  input  logic [1:0]                              s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // position, forward, pulsing, waiting_reverse, remaining
  output logic [((2*POS_BITS+3+7)/8)*8-1:0]       m_axis_tdata,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [2:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import stpc_pkg::*;

  localparam int OutFieldW = 2 * POS_BITS + 3;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  logic [POS_BITS-1:0]   max_pos;
  logic [DWELL_BITS-1:0] dwell_reload;

  logic                  in_valid_q;
  logic [1:0]            func_q;
  logic [POS_BITS-1:0]   target_q;
  logic                  out_valid_q, out_valid_d;
  logic                  advance;

  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [POS_BITS-1:0]   left_q, left_d;
  logic [DWELL_BITS-1:0] dwell_q, dwell_d;
  stpc_flags_t           flags_q, flags_d;

  stpc_regs #(
    .POS_BITS  (POS_BITS),
    .DWELL_BITS(DWELL_BITS)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_pos_o     (max_pos),
    .dwell_reload_o(dwell_reload)
  );

  stpc_update #(
    .POS_BITS  (POS_BITS),
    .DWELL_BITS(DWELL_BITS)
  ) u_update (
    .max_pos_i     (max_pos),
    .dwell_reload_i(dwell_reload),
    .func_i        (func_q),
    .target_i      (target_q),
    .pos_i         (pos_q),
    .left_i        (left_q),
    .dwell_i       (dwell_q),
    .flags_i       (flags_q),
    .pos_o         (pos_d),
    .left_o        (left_d),
    .dwell_o       (dwell_d),
    .flags_o       (flags_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q   <= s_axis_tuser;
      target_q <= s_axis_tdata[POS_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      left_q  <= '0;
      dwell_q <= '0;
      flags_q <= '{fwd: 1'b1, moving: 1'b0, delay: 1'b0};
    end else if (advance) begin
      pos_q   <= pos_d;
      left_q  <= left_d;
      dwell_q <= dwell_d;
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutFieldW){1'b0}}, left_q, flags_q.delay,
                          flags_q.moving, flags_q.fwd, pos_q};

  `STPC_ASSERT_INV(a_not_moving_and_waiting, clk_i, rst_ni,
    !(flags_q.moving && flags_q.delay), "moving and reversal pending at once")
  `STPC_ASSERT_INV(a_moving_has_steps, clk_i, rst_ni,
    !flags_q.moving || (left_q != '0), "moving with no steps left")
  `STPC_ASSERT(a_stall_holds_state, clk_i, rst_ni,
    (out_valid_q && !m_axis_tready) |=> ($stable(pos_q) && $stable(left_q)),
    "state changed while result stalled")

endmodule

### src/stpc_regs.sv
// APB configuration registers of the stepper position controller.
module stpc_regs #(
  parameter int POS_BITS   = 24,
  parameter int DWELL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [POS_BITS-1:0]   max_pos_o,
  output logic [DWELL_BITS-1:0] dwell_reload_o
);
  import stpc_pkg::*;

  logic [POS_BITS-1:0]   max_pos_q;
  logic [DWELL_BITS-1:0] dwell_reload_q;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pos_q      <= '1;
      dwell_reload_q <= DWELL_BITS'(DWELL_RESET_VAL);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_POS: max_pos_q      <= pwdata[POS_BITS-1:0];
        REG_DWELL:   dwell_reload_q <= pwdata[DWELL_BITS-1:0];
        default:     max_pos_q      <= max_pos_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_POS: prdata = 32'(max_pos_q);
      REG_DWELL:   prdata = 32'(dwell_reload_q);
      default:     prdata = '0;
    endcase
  end

  assign max_pos_o      = max_pos_q;
  assign dwell_reload_o = dwell_reload_q;

endmodule

### src/stpc_update.sv
// Next-state logic for one command item of the stepper position controller.
module stpc_update #(
  parameter int POS_BITS   = 24,
  parameter int DWELL_BITS = 16
) (
  input  logic [POS_BITS-1:0]   max_pos_i,
  input  logic [DWELL_BITS-1:0] dwell_reload_i,
  input  logic [1:0]            func_i,
  input  logic [POS_BITS-1:0]   target_i,
  input  logic [POS_BITS-1:0]   pos_i,
  input  logic [POS_BITS-1:0]   left_i,
  input  logic [DWELL_BITS-1:0] dwell_i,
  input  stpc_pkg::stpc_flags_t flags_i,
  output logic [POS_BITS-1:0]   pos_o,
  output logic [POS_BITS-1:0]   left_o,
  output logic [DWELL_BITS-1:0] dwell_o,
  output stpc_pkg::stpc_flags_t flags_o
);
  import stpc_pkg::*;

  logic [POS_BITS-1:0] dest;
  logic                want_fwd;

  assign dest = (target_i > max_pos_i) ? max_pos_i : target_i;

  always_comb begin
    pos_o    = pos_i;
    left_o   = left_i;
    dwell_o  = dwell_i;
    flags_o  = flags_i;
    want_fwd = 1'b0;
    unique case (func_i)
      FUNC_TICK: begin
        if (flags_i.moving) begin
          if (flags_i.fwd) begin
            if (pos_i < max_pos_i) pos_o = pos_i + 1'b1;
          end else if (pos_i != '0) begin
            pos_o = pos_i - 1'b1;
          end
          if (left_i <= POS_BITS'(1)) begin
            left_o         = '0;
            flags_o.moving = 1'b0;
          end else begin
            left_o = left_i - 1'b1;
          end
        end else if (dwell_i != '0) begin
          dwell_o = dwell_i - 1'b1;
        end else if (flags_i.delay) begin
          flags_o.fwd    = !flags_i.fwd;
          dwell_o        = dwell_reload_i;
          flags_o.moving = 1'b1;
          flags_o.delay  = 1'b0;
        end
      end
      FUNC_DEST: begin
        if (dest == pos_i) begin
          flags_o.moving = 1'b0;
          flags_o.delay  = 1'b0;
          left_o         = '0;
        end else begin
          want_fwd = dest > pos_i;
          left_o   = want_fwd ? (dest - pos_i) : (pos_i - dest);
          if (flags_i.fwd == want_fwd) begin
            dwell_o        = dwell_reload_i;
            flags_o.moving = 1'b1;
            flags_o.delay  = 1'b0;
          end else begin
            flags_o.delay  = 1'b1;
            flags_o.moving = 1'b0;
          end
        end
      end
      FUNC_STOP: begin
        flags_o.moving = 1'b0;
        flags_o.delay  = 1'b0;
        left_o         = '0;
      end
      default: begin
        pos_o = pos_i;
      end
    endcase
  end

endmodule
